>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion macros shared by the deframer RTL.
// ----------------------------------------------------------------------------
// Each macro checks a property on the rising edge of clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checked only outside reset.
`define ASSERT_RUN(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Checked at every edge, reset included.
`define ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`else

`define ASSERT_RUN(lbl, prop)
`define ASSERT_ALWAYS(lbl, prop)

`endif

`endif

>>> src/spd_pkg.sv
// ----------------------------------------------------------------------------
// spd_pkg
// Types and constants for the servo bus packet deframer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package spd_pkg;

  // Header byte value and the offset between length byte and payload length.
  localparam logic [7:0] HDR_BYTE          = 8'hFF;
  localparam logic [7:0] LEN_OVERHEAD      = 8'd2;
  localparam logic [7:0] MAX_PAYLOAD_RESET = 8'd250;

  // Item kinds.
  localparam logic FUNC_BYTE    = 1'b0;
  localparam logic FUNC_TIMEOUT = 1'b1;

  // Result kinds.
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  // End-of-frame status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_CSUM    = 2'd1;
  localparam logic [1:0] ST_LEN     = 2'd2;
  localparam logic [1:0] ST_TIMEOUT = 2'd3;

  // Frame phases.
  typedef enum logic [2:0] {
    PH_HDR1 = 3'd0,
    PH_HDR2 = 3'd1,
    PH_ID   = 3'd2,
    PH_LEN  = 3'd3,
    PH_ERR  = 3'd4,
    PH_DATA = 3'd5,
    PH_SUM  = 3'd6
  } phase_t;

  typedef struct packed {
    logic       func;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic       result_kind;
    logic [7:0] payload_byte;
    logic [7:0] servo_id;
    logic [7:0] servo_error;
    logic [7:0] payload_len;
    logic [1:0] frame_status;
    logic       frame_last;
  } out_item_t;

endpackage

`default_nettype wire

>>> src/spd_parser.sv
// ----------------------------------------------------------------------------
// spd_parser
// Frame phase machine: holds the frame fields and running checksum, and
// works out the result of one item in a single pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module spd_parser
  import spd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      step,
  input  wire in_item_t  item,
  input  wire logic [7:0] max_len,
  output logic           res_vld,
  output out_item_t      res
);

  phase_t     phase, phase_next;
  logic [7:0] frame_id, frame_id_next;
  logic [7:0] frame_len, frame_len_next;
  logic [7:0] frame_err, frame_err_next;
  logic [7:0] bytes_left, bytes_left_next;
  logic [7:0] running_sum, running_sum_next;

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HDR1;
      frame_id    <= '0;
      frame_len   <= '0;
      frame_err   <= '0;
      bytes_left  <= '0;
      running_sum <= '0;
    end else begin
      phase       <= phase_next;
      frame_id    <= frame_id_next;
      frame_len   <= frame_len_next;
      frame_err   <= frame_err_next;
      bytes_left  <= bytes_left_next;
      running_sum <= running_sum_next;
    end
  end

  // Next state and result for the item at hand.
  always_comb begin
    logic [7:0] b;
    logic [7:0] len_m2;
    logic       clear;

    b      = item.rx_byte;
    len_m2 = b - LEN_OVERHEAD;
    clear  = 1'b0;

    phase_next       = phase;
    frame_id_next    = frame_id;
    frame_len_next   = frame_len;
    frame_err_next   = frame_err;
    bytes_left_next  = bytes_left;
    running_sum_next = running_sum;

    res_vld          = 1'b0;
    res.result_kind  = KIND_PAYLOAD;
    res.payload_byte = '0;
    res.servo_id     = frame_id;
    res.servo_error  = frame_err;
    res.payload_len  = frame_len;
    res.frame_status = ST_OK;
    res.frame_last   = 1'b0;

    if (step) begin
      if (item.func == FUNC_TIMEOUT) begin
        res_vld          = 1'b1;
        res.result_kind  = KIND_STATUS;
        res.frame_last   = 1'b1;
        res.frame_status = ST_TIMEOUT;
        clear            = 1'b1;
      end else begin
        case (phase)
          PH_HDR2: begin
            phase_next = (b == HDR_BYTE) ? PH_ID : PH_HDR1;
          end
          PH_ID: begin
            frame_id_next    = b;
            running_sum_next = b;
            phase_next       = PH_LEN;
          end
          PH_LEN: begin
            if (b < LEN_OVERHEAD) begin
              res_vld          = 1'b1;
              res.result_kind  = KIND_STATUS;
              res.frame_last   = 1'b1;
              res.frame_status = ST_LEN;
              res.payload_len  = '0;
              clear            = 1'b1;
            end else if (len_m2 > max_len) begin
              res_vld          = 1'b1;
              res.result_kind  = KIND_STATUS;
              res.frame_last   = 1'b1;
              res.frame_status = ST_LEN;
              res.payload_len  = len_m2;
              clear            = 1'b1;
            end else begin
              running_sum_next = running_sum + b;
              frame_len_next   = len_m2;
              bytes_left_next  = len_m2;
              phase_next       = PH_ERR;
            end
          end
          PH_ERR: begin
            frame_err_next   = b;
            running_sum_next = running_sum + b;
            phase_next       = (bytes_left != '0) ? PH_DATA : PH_SUM;
          end
          PH_DATA: begin
            running_sum_next = running_sum + b;
            bytes_left_next  = bytes_left - 8'd1;
            if (bytes_left == 8'd1) begin
              phase_next = PH_SUM;
            end
            res_vld          = 1'b1;
            res.payload_byte = b;
          end
          PH_SUM: begin
            res_vld          = 1'b1;
            res.result_kind  = KIND_STATUS;
            res.frame_last   = 1'b1;
            res.frame_status = (b == ~running_sum) ? ST_OK : ST_CSUM;
            clear            = 1'b1;
          end
          default: begin
            phase_next = (b == HDR_BYTE) ? PH_HDR2 : PH_HDR1;
          end
        endcase
      end

      // A frame that ends, by whatever cause, leaves no fields behind.
      if (clear) begin
        phase_next       = PH_HDR1;
        frame_id_next    = '0;
        frame_len_next   = '0;
        frame_err_next   = '0;
        bytes_left_next  = '0;
        running_sum_next = '0;
      end
    end
  end

  // Payload bytes come only from the data phase.
  `ASSERT_RUN(a_payload_in_data, (res_vld && !res.result_kind) |-> (phase == PH_DATA))
  // Every status result returns the machine to header hunting.
  `ASSERT_RUN(a_status_rehunt, (res_vld && res.result_kind) |=> (phase == PH_HDR1))
  // The data phase always has bytes still to come.
  `ASSERT_RUN(a_data_count, (phase == PH_DATA) |-> (bytes_left != '0))

endmodule

`default_nettype wire

>>> src/spd_out_reg.sv
// ----------------------------------------------------------------------------
// spd_out_reg
// Result register: holds one result until the downstream side takes it and
// tells the parser stage when a new result may be written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module spd_out_reg
  import spd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      load,
  input  wire out_item_t res,
  input  wire logic      ready,
  output logic           free,
  output logic           valid,
  output out_item_t      data
);

  // The slot may be reused in the cycle its transaction completes.
  assign free = !valid || ready;

  // Valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (ready) begin
      valid <= 1'b0;
    end
  end

  // Payload.
  always_ff @(posedge clk) begin
    if (load) begin
      data <= res;
    end
  end

  // A load never overwrites a result still waiting to be taken.
  `ASSERT_RUN(a_no_overwrite, load |-> free)
  // Status results are the ones that close a frame.
  `ASSERT_RUN(a_last_is_status, valid |-> (data.frame_last == data.result_kind))
  // A loaded result is presented on the next cycle.
  `ASSERT_RUN(a_load_shows, load |=> valid)

endmodule

`default_nettype wire

>>> src/servo_packet_deframer.sv
// ----------------------------------------------------------------------------
// servo_packet_deframer
// Receiver for half-duplex servo bus packets: finds the 0xFF 0xFF header,
// captures id, length and error bytes, passes payload bytes out and ends
// each frame with a status result (ok, checksum, length error, timeout).
//
//   Channel   Signals                       Transaction carries
//   in        in_valid  in_ready  in_data   one bus byte or a timeout event
//   out       out_valid out_ready out_data  payload byte or frame status
//   cfg       cfg_valid cfg_ready cfg_data  max_payload_len
//
// One item is accepted per cycle while out is not stalled; it is held in the
// input register, and its result, if any, is worked out by the parser in a
// single pass and loaded into the result register, which presents it on out.
// Reset clears the frame state and sets max_payload_len to 250.
// A stall on out holds the result register and, through it, the input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module servo_packet_deframer
  import spd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire in_item_t   in_data,
  output logic            out_valid,
  input  wire logic       out_ready,
  output out_item_t       out_data,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [7:0] cfg_data
);

  logic       in_vld;
  in_item_t   in_q;
  logic [7:0] max_len;
  logic       out_free;
  logic       step;
  logic       res_vld;
  out_item_t  res;

  // A write is taken in any cycle; the sender keeps writes to times when no
  // transaction is in flight.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= MAX_PAYLOAD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_len <= cfg_data;
    end
  end

  // Input register: advances when the result slot is free.
  assign step     = in_vld && out_free;
  assign in_ready = !in_vld || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_vld <= 1'b1;
    end else if (step) begin
      in_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q <= in_data;
    end
  end

  // Phase machine.
  spd_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .item    (in_q),
    .max_len (max_len),
    .res_vld (res_vld),
    .res     (res)
  );

  // Result register.
  spd_out_reg u_out (
    .clk   (clk),
    .rst   (rst),
    .load  (res_vld),
    .res   (res),
    .ready (out_ready),
    .free  (out_free),
    .valid (out_valid),
    .data  (out_data)
  );

endmodule

`default_nettype wire
